// ----- design/dwg_pkg.sv -----
// ----------------------------------------------------------------------------
// dwg_pkg
// Shared types and constants of the DAC waveform generator: field widths,
// mode codes, configuration register indexes and the per-item state record.
// ----------------------------------------------------------------------------
`default_nettype none

package dwg_pkg;

  localparam int unsigned CodeWidth     = 12;
  localparam int unsigned PrescaleWidth = 17;
  localparam int unsigned StepWidth     = 5;
  localparam int unsigned ButtonWidth   = 4;
  localparam int unsigned WordWidth     = 16;
  localparam int unsigned ModeWidth     = 3;
  localparam int unsigned CfgIdxWidth   = 3;
  localparam int unsigned CfgDataWidth  = 16;

  localparam logic [WordWidth-1:0] DacCtrl = 16'h3000;
  localparam logic [CodeWidth-1:0] CodeMax = {CodeWidth{1'b1}};

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] RegSquareReload   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegSawtoothReload = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegTriangleOffset = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegStepSize       = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegStepCount      = 3'd4;

  // mode codes as they appear on the result stream
  localparam logic [ModeWidth-1:0] CodeMenu     = 3'd0;
  localparam logic [ModeWidth-1:0] CodeDc       = 3'd1;
  localparam logic [ModeWidth-1:0] CodeSquare   = 3'd2;
  localparam logic [ModeWidth-1:0] CodeSawtooth = 3'd3;
  localparam logic [ModeWidth-1:0] CodeTriangle = 3'd4;

  typedef enum logic [4:0] {
    MODE_MENU     = 5'b00001,
    MODE_DC       = 5'b00010,
    MODE_SQUARE   = 5'b00100,
    MODE_SAWTOOTH = 5'b01000,
    MODE_TRIANGLE = 5'b10000
  } mode_e;

  typedef struct packed {
    logic [15:0]          square_reload;
    logic [15:0]          sawtooth_reload;
    logic [15:0]          triangle_offset;
    logic [CodeWidth-1:0] step_size;
    logic [StepWidth-1:0] step_count;
  } cfg_t;

  typedef struct packed {
    mode_e                    mode;
    logic [PrescaleWidth-1:0] prescale;
    logic [StepWidth-1:0]     step;
    logic [StepWidth-1:0]     down;
    logic                     rising;
  } wave_state_t;

  typedef struct packed {
    logic                 dac_write;
    logic [WordWidth-1:0] dac_word;
    logic [ModeWidth-1:0] mode;
  } result_t;

  localparam wave_state_t StateReset = '{
    mode:     MODE_MENU,
    prescale: '0,
    step:     '0,
    down:     '0,
    rising:   1'b1
  };

  function automatic logic [ModeWidth-1:0] mode_code(mode_e m);
    logic [ModeWidth-1:0] c;
    unique case (m)
      MODE_MENU:     c = CodeMenu;
      MODE_DC:       c = CodeDc;
      MODE_SQUARE:   c = CodeSquare;
      MODE_SAWTOOTH: c = CodeSawtooth;
      MODE_TRIANGLE: c = CodeTriangle;
      default:       c = CodeMenu;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/dac_waveform_generator.sv -----
// ----------------------------------------------------------------------------
// dac_waveform_generator
// DAC function generator: DC, square, sawtooth and triangle waves selected
// by buttons, one DAC word per timer cycle.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                    payload
//  s_axis   in         s_axis_tvalid/s_axis_tready  tdata: buttons_n, pot_sample
//  m_axis   out        m_axis_tvalid/m_axis_tready  tdata: dac_word;
//                                                   tuser: dac_write, mode
//  cfg      in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
//  One item per cycle sustained while m_axis_tready allows; an item passes the
//  input register, then the per-item logic into the result register.
//  Reset clears the mode to menu, the prescaler and the wave counters, and
//  loads the configuration defaults. No clearing pass.
//  A stalled result register holds; the input register still takes one more
//  item, after which s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dac_waveform_generator
  import dwg_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output      logic                    s_axis_tready,
  input  wire logic [15:0]             s_axis_tdata,  // [3:0] buttons_n, [15:4] pot_sample
  output      logic                    m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output      logic [15:0]             m_axis_tdata,  // [15:0] dac_word
  output      logic [3:0]              m_axis_tuser,  // [0] dac_write, [3:1] mode
  input  wire logic                    cfg_valid_i,
  output      logic                    cfg_ready_o,
  input  wire logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i
);

  cfg_t                   cfg;
  wave_state_t            state_q, state_d;
  result_t                result, out_q;
  logic                   in_valid_q, out_valid_q;
  logic [ButtonWidth-1:0] in_buttons_q;
  logic [CodeWidth-1:0]   in_pot_q;
  logic                   advance;

  assign cfg_ready_o = 1'b1;

  dwg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dwg_step u_step (
    .state_i      (state_q),
    .cfg_i        (cfg),
    .buttons_n_i  (in_buttons_q),
    .pot_sample_i (in_pot_q),
    .state_o      (state_d),
    .result_o     (result)
  );

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_buttons_q <= s_axis_tdata[ButtonWidth-1:0];
      in_pot_q     <= s_axis_tdata[ButtonWidth+CodeWidth-1:ButtonWidth];
    end
    if (advance && in_valid_q) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.dac_word;
  assign m_axis_tuser  = {out_q.mode, out_q.dac_write};

  // menu results carry no DAC word
  a_menu_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("menu result carries a DAC word");

  // every DAC word carries the control bits
  a_ctrl_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[15:12] == DacCtrl[15:12]))
    else $error("DAC word without control bits");

  // a falling ramp exists only in triangle mode
  a_falling_in_triangle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.rising |-> (state_q.mode == MODE_TRIANGLE))
    else $error("falling ramp outside triangle mode");

  // DC mode leaves the prescaler idle
  a_dc_prescale_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode == MODE_DC) |-> (state_q.prescale == '0))
    else $error("prescaler running in DC mode");

  // an empty result register never blocks the input side
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire

// ----- design/dwg_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// dwg_cfg_regs
// Configuration register file; one register written per write transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module dwg_cfg_regs
  import dwg_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i,
  output      cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegSquareReload:   cfg_d.square_reload   = cfg_data_i;
        RegSawtoothReload: cfg_d.sawtooth_reload = cfg_data_i;
        RegTriangleOffset: cfg_d.triangle_offset = cfg_data_i;
        RegStepSize:       cfg_d.step_size       = cfg_data_i[CodeWidth-1:0];
        RegStepCount:      cfg_d.step_count      = cfg_data_i[StepWidth-1:0];
        default:           cfg_d = cfg_q; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.square_reload   <= 16'd163;
      cfg_q.sawtooth_reload <= 16'd15;
      cfg_q.triangle_offset <= 16'd20;
      cfg_q.step_size       <= 12'd74;
      cfg_q.step_count      <= 5'd20;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- design/dwg_step.sv -----
// ----------------------------------------------------------------------------
// dwg_step
// Per-item logic: button decode, mode change, prescaler tick, wave counters
// and the DAC code for one timer cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dwg_step
  import dwg_pkg::*;
(
  input  wire  wave_state_t            state_i,
  input  wire  cfg_t                   cfg_i,
  input  wire  logic [ButtonWidth-1:0] buttons_n_i,
  input  wire  logic [CodeWidth-1:0]   pot_sample_i,
  output       wave_state_t            state_o,
  output       result_t                result_o
);

  logic [ButtonWidth-1:0]   pressed;
  logic                     any_press;
  mode_e                    key_mode;
  logic [PrescaleWidth-1:0] terminal;
  logic                     tick;
  logic [StepWidth-1:0]     step_inc;
  logic [StepWidth-1:0]     saw_step;
  logic [StepWidth-1:0]     down_dec;
  logic [StepWidth-1:0]     mul_op;
  logic [CodeWidth+StepWidth-1:0] product;
  logic [CodeWidth-1:0]     ramp_code;
  logic [CodeWidth-1:0]     code;

  assign pressed   = ~buttons_n_i;
  assign any_press = |pressed;

  always_comb begin
    priority if (pressed[3]) key_mode = MODE_TRIANGLE;
    else if (pressed[2])     key_mode = MODE_SAWTOOTH;
    else if (pressed[1])     key_mode = MODE_SQUARE;
    else                     key_mode = MODE_DC;
  end

  always_comb begin
    unique case (state_i.mode)
      MODE_SQUARE:   terminal = {1'b0, cfg_i.square_reload};
      MODE_SAWTOOTH: terminal = {1'b0, cfg_i.sawtooth_reload};
      default: terminal = {{(PrescaleWidth-CodeWidth){1'b0}}, pot_sample_i}
                        + {1'b0, cfg_i.triangle_offset};
    endcase
  end

  assign tick     = (state_i.prescale >= terminal);
  assign step_inc = tick ? state_i.step + 5'd1 : state_i.step;
  assign saw_step = (step_inc >= cfg_i.step_count) ? '0 : step_inc;
  assign down_dec = (tick && (state_i.down != '0)) ? state_i.down - 5'd1 : state_i.down;

  // one shared multiplier for the ramp codes
  always_comb begin
    unique case (state_i.mode)
      MODE_SAWTOOTH: mul_op = saw_step;
      default:       mul_op = state_i.rising ? step_inc : down_dec;
    endcase
  end

  assign product   = {{CodeWidth{1'b0}}, mul_op} * {{StepWidth{1'b0}}, cfg_i.step_size};
  assign ramp_code = (|product[CodeWidth+StepWidth-1:CodeWidth]) ? CodeMax
                                                                 : product[CodeWidth-1:0];

  always_comb begin
    state_o  = state_i;
    code     = '0;
    result_o = '{dac_write: 1'b0, dac_word: '0, mode: CodeMenu};

    if (state_i.mode == MODE_MENU || any_press) begin
      // a press in a wave mode returns to the menu; in the menu it selects
      state_o = StateReset;
      if (state_i.mode == MODE_MENU && any_press) begin
        state_o.mode = key_mode;
      end
      result_o.mode = mode_code(state_o.mode);
    end else begin
      if (state_i.mode != MODE_DC) begin
        state_o.prescale = tick ? '0 : state_i.prescale + 17'd1;
      end
      unique case (state_i.mode)
        MODE_DC: begin
          code = pot_sample_i;
        end
        MODE_SQUARE: begin
          state_o.step = step_inc;
          code = step_inc[0] ? pot_sample_i : '0;
        end
        MODE_SAWTOOTH: begin
          state_o.step = saw_step;
          code = ramp_code;
        end
        default: begin
          if (state_i.rising) begin
            state_o.step = step_inc;
            code = ramp_code;
            if (step_inc >= cfg_i.step_count) begin
              state_o.rising = 1'b0;
              state_o.step   = '0;
              state_o.down   = cfg_i.step_count;
            end
          end else begin
            state_o.down = down_dec;
            code = ramp_code;
            if (down_dec == '0) begin
              state_o.rising = 1'b1;
              state_o.step   = '0;
              code = '0;
            end
          end
        end
      endcase
      result_o.dac_write = 1'b1;
      result_o.dac_word  = DacCtrl | {{(WordWidth-CodeWidth){1'b0}}, code};
      result_o.mode      = mode_code(state_i.mode);
    end
  end

endmodule

`default_nettype wire

// ----- verif/dac_waveform_generator_tb.sv -----
// ----------------------------------------------------------------------------
// dac_waveform_generator_tb
// Streams panel samples (buttons and pot) into the generator and checks each
// DAC result against a cycle-accurate wave predictor kept in the bench.
// Runs a short directed pass, then phases of button-driven sessions under
// several register settings, with random idling on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dac_waveform_generator_tb;
  import dwg_pkg::*;

  typedef struct packed {
    logic [CodeWidth-1:0]   pot_sample;
    logic [ButtonWidth-1:0] buttons_n;
  } panel_sample_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [15:0]             s_axis_tdata = '0;  // [3:0] buttons_n, [15:4] pot_sample
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [15:0]             m_axis_tdata;       // [15:0] dac_word
  logic [3:0]              m_axis_tuser;       // [0] dac_write, [3:1] mode
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxWidth-1:0]  cfg_index_i = '0;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;

  // register shadow, loaded with the reset defaults
  logic [15:0]          cfg_square = 16'd163;
  logic [15:0]          cfg_sawtooth = 16'd15;
  logic [15:0]          cfg_tri_offset = 16'd20;
  logic [CodeWidth-1:0] cfg_step_size = 12'd74;
  logic [StepWidth-1:0] cfg_step_count = 5'd20;

  // predicted generator state
  logic [ModeWidth-1:0]     wave_mode = CodeMenu;
  logic [PrescaleWidth-1:0] prescale = '0;
  logic [StepWidth-1:0]     step = '0;
  logic [StepWidth-1:0]     down = '0;
  logic                     rising = 1'b1;

  panel_sample_t sample_q[$];
  result_t       expected_dac_q[$];

  int  samples_queued = 0;
  int  samples_taken = 0;
  int  results_seen = 0;
  int  fail_count = 0;
  int  mode_hits[5] = '{default: 0};
  int  send_gap = 0;
  int  recv_gap = 0;
  bit  send_gaps_on = 1'b1;
  bit  recv_gaps_on = 1'b1;
  int  settings_used = 1;
  result_t got;
  result_t want;

  dac_waveform_generator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_500_000;
    $display("dac_waveform_generator: mismatch");
    $finish;
  end

  function automatic int pick_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [CodeWidth-1:0] ramp_level(logic [StepWidth-1:0] n);
    logic [16:0] product;
    product = 17'(n) * 17'(cfg_step_size);
    return (product > 17'(CodeMax)) ? CodeMax : product[CodeWidth-1:0];
  endfunction

  // Advance the predicted generator by one timer cycle.
  function automatic result_t advance_wave(panel_sample_t s);
    logic [ButtonWidth-1:0]   held;
    logic [ModeWidth-1:0]     key;
    logic [PrescaleWidth-1:0] terminal;
    logic [CodeWidth-1:0]     code;
    logic                     tick;
    result_t                  r;
    held = ~s.buttons_n;
    key = held[3] ? CodeTriangle : held[2] ? CodeSawtooth :
          held[1] ? CodeSquare : held[0] ? CodeDc : CodeMenu;
    if (wave_mode == CodeMenu || key != CodeMenu) begin
      // select from the menu, or drop back to it on any press
      wave_mode = (wave_mode == CodeMenu) ? key : CodeMenu;
      prescale = '0;
      step = '0;
      down = '0;
      rising = 1'b1;
      r = '{dac_write: 1'b0, dac_word: '0, mode: wave_mode};
      return r;
    end
    tick = 1'b0;
    terminal = '0;
    if (wave_mode != CodeDc) begin
      case (wave_mode)
        CodeSquare:   terminal = PrescaleWidth'(cfg_square);
        CodeSawtooth: terminal = PrescaleWidth'(cfg_sawtooth);
        default:      terminal = PrescaleWidth'(s.pot_sample) + PrescaleWidth'(cfg_tri_offset);
      endcase
      if (prescale >= terminal) begin
        prescale = '0;
        tick = 1'b1;
      end else begin
        prescale = prescale + 1'b1;
      end
    end
    code = '0;
    case (wave_mode)
      CodeDc: code = s.pot_sample;
      CodeSquare: begin
        if (tick) step = step + 1'b1;
        code = step[0] ? s.pot_sample : '0;
      end
      CodeSawtooth: begin
        if (tick) step = step + 1'b1;
        if (step >= cfg_step_count) step = '0;
        code = ramp_level(step);
      end
      default: begin
        if (rising) begin
          if (tick) step = step + 1'b1;
          code = ramp_level(step);
          if (step >= cfg_step_count) begin
            rising = 1'b0;
            step = '0;
            down = cfg_step_count;
          end
        end else begin
          // saturating count down, turn at zero
          if (tick && down != '0) down = down - 1'b1;
          code = ramp_level(down);
          if (down == '0) begin
            rising = 1'b1;
            step = '0;
            code = '0;
          end
        end
      end
    endcase
    r = '{dac_write: 1'b1, dac_word: DacCtrl | WordWidth'(code), mode: wave_mode};
    return r;
  endfunction

  // Sample driver: present queued samples, predict on each transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_dac_q.push_back(advance_wave(s_axis_tdata));
        samples_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= sample_q.pop_front();
          send_gap = pick_gap(send_gaps_on);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transaction with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.dac_write = m_axis_tuser[0];
        got.mode      = m_axis_tuser[3:1];
        got.dac_word  = m_axis_tdata;
        results_seen++;
        if (expected_dac_q.size() == 0) begin
          $error("result with nothing expected: word %h mode %0d", got.dac_word, got.mode);
          fail_count++;
        end else begin
          want = expected_dac_q.pop_front();
          if (want.mode < 5) mode_hits[want.mode]++;
          if (got.dac_write !== want.dac_write) begin
            $error("dac_write: expected %0d, got %0d", want.dac_write, got.dac_write);
            fail_count++;
          end
          if (got.dac_word !== want.dac_word) begin
            $error("dac_word: expected %h, got %h", want.dac_word, got.dac_word);
            fail_count++;
          end
          if (got.mode !== want.mode) begin
            $error("mode: expected %0d, got %0d", want.mode, got.mode);
            fail_count++;
          end
        end
        // hold off for a long stretch now and then so the input side backs up
        if (results_seen % 400 == 100) recv_gap = $urandom_range(60, 100);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap = pick_gap(recv_gaps_on);
      end
    end
  end

  task automatic push_sample(logic [ButtonWidth-1:0] buttons_n, logic [CodeWidth-1:0] pot);
    sample_q.push_back('{pot_sample: pot, buttons_n: buttons_n});
    samples_queued++;
  endtask

  function automatic logic [CodeWidth-1:0] pick_pot(bit keep_low);
    int r;
    r = $urandom_range(0, 9);
    if (keep_low && $urandom_range(0, 15) != 0) return 12'($urandom_range(0, 7));
    if (r == 0) return '0;
    if (r == 1) return CodeMax;
    return 12'($urandom_range(0, 4095));
  endfunction

  // One menu selection, a run of released buttons, then a press to leave.
  task automatic queue_session();
    logic [ButtonWidth-1:0] press;
    int  run_len;
    bit  keep_low;
    if ($urandom_range(0, 3) == 0) push_sample(4'hF, pick_pot(1'b0));
    if ($urandom_range(0, 4) != 0) press = ~(4'b0001 << $urandom_range(0, 3));
    else press = 4'($urandom_range(0, 14));
    push_sample(press, pick_pot(1'b0));
    // triangle rate follows the pot: keep it low so ramps turn within the run
    keep_low = !press[3];
    run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250) : $urandom_range(5, 60);
    for (int n = 0; n < run_len; n++) begin
      if ($urandom_range(0, 39) == 0) push_sample(4'($urandom_range(0, 15)), pick_pot(1'b0));
      else push_sample(4'hF, pick_pot(keep_low));
    end
    push_sample(4'($urandom_range(0, 14)), pick_pot(1'b0));
  endtask

  task automatic wait_for_drain();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || s_axis_tvalid || expected_dac_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      RegSquareReload:   cfg_square     = value;
      RegSawtoothReload: cfg_sawtooth   = value;
      RegTriangleOffset: cfg_tri_offset = value;
      RegStepSize:       cfg_step_size  = value[CodeWidth-1:0];
      RegStepCount:      cfg_step_count = value[StepWidth-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [15:0]          sq_val;
    logic [15:0]          saw_val;
    logic [15:0]          tri_val;
    logic [CodeWidth-1:0] size_val;
    logic [StepWidth-1:0] count_val;
    int                   phase;
    int                   phase_end;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: idle menu, each selection, priority, pot extremes, exits
    push_sample(4'hF, 12'h000);
    push_sample(4'hE, 12'hFFF);            // DC
    push_sample(4'hF, 12'h000);
    push_sample(4'hF, 12'hFFF);
    push_sample(4'hF, 12'hAAA);
    push_sample(4'hF, 12'h555);
    push_sample(4'h6, 12'h000);            // two pressed: back to menu
    push_sample(4'h0, 12'h123);            // all pressed: triangle wins
    push_sample(4'hF, 12'h000);
    push_sample(4'hF, 12'h000);
    push_sample(4'hD, 12'h000);            // exit
    push_sample(4'h9, 12'h800);            // S3 over S2: sawtooth
    push_sample(4'hF, 12'h001);
    push_sample(4'h0, 12'h000);            // exit
    push_sample(4'hD, 12'hFFF);            // square
    push_sample(4'hF, 12'hFFF);
    push_sample(4'hF, 12'hFFF);
    push_sample(4'hB, 12'h000);            // exit
    push_sample(4'h7, 12'hFFF);            // triangle
    push_sample(4'hF, 12'hFFF);
    push_sample(4'hF, 12'h000);
    push_sample(4'hE, 12'h000);            // exit
    push_sample(4'hF, 12'hFFF);

    phase = 0;
    while (samples_queued < 1450) begin
      wait_for_drain();
      case (phase)
        0: begin  // fastest ticks, clamped steps, longest ramp
          sq_val = '0; saw_val = '0; tri_val = '0; size_val = CodeMax; count_val = 5'd31;
        end
        1: begin  // shortest legal ramp
          sq_val = 16'd3; saw_val = 16'd2; tri_val = 16'd1; size_val = 12'd200;
          count_val = 5'd1;
        end
        2: begin  // slowest prescalers, flat ramp, zero step count
          sq_val = 16'hFFFF; saw_val = 16'hFFFF; tri_val = 16'hFFFF; size_val = '0;
          count_val = '0;
        end
        3: begin  // back to the reset defaults
          sq_val = 16'd163; saw_val = 16'd15; tri_val = 16'd20; size_val = 12'd74;
          count_val = 5'd20;
        end
        default: begin
          sq_val    = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 5));
          saw_val   = 16'($urandom_range(0, 3));
          tri_val   = 16'($urandom_range(0, 2));
          size_val  = 12'($urandom_range(0, 4095));
          count_val = ($urandom_range(0, 5) == 0) ? 5'd31 : 5'($urandom_range(0, 10));
        end
      endcase
      write_reg(RegSquareReload, sq_val);
      write_reg(RegSawtoothReload, saw_val);
      write_reg(RegTriangleOffset, tri_val);
      write_reg(RegStepSize, 16'(size_val));
      write_reg(RegStepCount, 16'(count_val));
      settings_used++;
      @(negedge clk_i);
      // one phase runs with no idling at all
      send_gaps_on = (phase != 1) && ($urandom_range(0, 3) != 0);
      recv_gaps_on = (phase != 1) && ($urandom_range(0, 3) != 0);
      phase_end = samples_queued + 180;
      if (phase_end > 1450) phase_end = 1450;
      while (samples_queued < phase_end) queue_session();
      phase++;
    end

    wait_for_drain();
    repeat (10) @(negedge clk_i);
    $display("covered %0d panel samples, %0d results, %0d register settings",
             samples_taken, results_seen, settings_used);
    $display("results by mode (menu dc square sawtooth triangle): %0d %0d %0d %0d %0d",
             mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4]);
    if (fail_count == 0 && expected_dac_q.size() == 0) begin
      $display("dac_waveform_generator: match");
    end else begin
      $display("dac_waveform_generator: mismatch");
    end
    $finish;
  end

endmodule
